// ===== rtl/lgge_pkg.sv =====
// shared types and constants of the life grid generation engine
`timescale 1ns / 1ps

package lgge_pkg;

    localparam int OP_W  = 2;
    localparam int ROW_W = 6;
    localparam int COL_W = 7;

    localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OP_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    typedef logic [1:0] t_vsum;
    typedef logic [3:0] t_ncnt;

    localparam t_ncnt BIRTH_CNT   = 4'd3;
    localparam t_ncnt SURVIVE_CNT = 4'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WR,
        S_RD,
        S_STEP,
        S_DONE
    } t_state;

endpackage

// ===== rtl/lgge_ifs.sv =====
// valid/ready channel interfaces for operation and result beats
`timescale 1ns / 1ps

interface lgge_in_if
    import lgge_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             cell_in;

    modport source (output valid, output operation, output row, output col,
                    output cell_in, input ready);
    modport sink   (input valid, input operation, input row, input col,
                    input cell_in, output ready);
endinterface

interface lgge_out_if;
    logic valid;
    logic ready;
    logic cell_out;

    modport source (output valid, output cell_out, input ready);
    modport sink   (input valid, input cell_out, output ready);
endinterface

// ===== rtl/lgge_cell.sv =====
// one column cell: three-row window and b3/s23 rule
`timescale 1ns / 1ps

module lgge_cell
    import lgge_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_shift,
    input  logic  i_bit,
    input  t_vsum i_vsum_l,
    input  t_vsum i_vsum_r,
    output t_vsum o_vsum,
    output logic  o_next
);

    logic  r_top;
    logic  r_mid;
    logic  r_bot;
    t_ncnt total;
    t_ncnt ncnt;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_top <= r_mid;
            r_mid <= r_bot;
            r_bot <= i_bit;
        end
    end

    assign o_vsum = t_vsum'({1'b0, r_top}) + t_vsum'({1'b0, r_mid}) + t_vsum'({1'b0, r_bot});

    always_comb begin
        total  = t_ncnt'(i_vsum_l) + t_ncnt'(o_vsum) + t_ncnt'(i_vsum_r);
        ncnt   = total - t_ncnt'(r_mid);
        o_next = (ncnt == BIRTH_CNT) || (r_mid && (ncnt == SURVIVE_CNT));
    end

endmodule

// ===== rtl/lgge_chain.sv =====
// row of column cells that computes one new board row per shift
`timescale 1ns / 1ps

module lgge_chain
    import lgge_pkg::*;
#(
    parameter int WIDTH = 80
) (
    input  logic             i_clk,
    input  logic             i_shift,
    input  logic [WIDTH-1:0] i_row_bits,
    output logic [WIDTH-1:0] o_next
);

    t_vsum vsum [WIDTH];
    logic  nxt  [WIDTH];

    for (genvar c = 0; c < WIDTH; c++) begin : g_col
        t_vsum vl;
        t_vsum vr;

        if (c == 0) begin : g_l
            assign vl = '0;
        end else begin : g_l
            assign vl = vsum[c-1];
        end

        if (c == WIDTH - 1) begin : g_r
            assign vr = '0;
        end else begin : g_r
            assign vr = vsum[c+1];
        end

        lgge_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (i_shift),
            .i_bit    (i_row_bits[c]),
            .i_vsum_l (vl),
            .i_vsum_r (vr),
            .o_vsum   (vsum[c]),
            .o_next   (nxt[c])
        );

        // border columns always die
        if (c == 0 || c == WIDTH - 1) begin : g_o
            assign o_next[c] = 1'b0;
        end else begin : g_o
            assign o_next[c] = nxt[c];
        end
    end

endmodule

// ===== rtl/life_grid_generation_engine.sv =====
// top level: board row memory, operation sequencer and result register
// write and read: the row is first read into a register; the write-back and result load wait for a free result slot
// a step gives its result once every row has been written back and the result slot is free
// one item at a time; a step streams each board row once through the cell chain
// reset: synchronous active low; per-row valid flags clear so the board reads dead
`timescale 1ns / 1ps

module life_grid_generation_engine
    import lgge_pkg::*;
#(
    parameter int WIDTH  = 80,
    parameter int HEIGHT = 50
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    lgge_in_if.sink     i_in,
    lgge_out_if.source  o_out
);

    localparam int RW = $clog2(HEIGHT);
    localparam int CW = $clog2(WIDTH);
    localparam int KW = $clog2(HEIGHT + 1);
    localparam int XR = (RW > ROW_W) ? RW : ROW_W;
    localparam int XC = (CW > COL_W) ? CW : COL_W;
    localparam logic [KW-1:0] K_LAST = KW'(HEIGHT);

    logic [WIDTH-1:0] r_mem [HEIGHT];
    logic [HEIGHT-1:0] r_row_vld;

    t_state r_state;
    t_state n_state;

    logic [WIDTH-1:0] r_rd_data;
    logic             r_rd_vld;
    logic [RW-1:0]    r_row;
    logic [CW-1:0]    r_col;
    logic             r_cell_in;
    logic [KW-1:0]    r_k;
    logic             r_iss;
    logic             r_p1_vld;
    logic             r_p1_zero;
    logic [KW-1:0]    r_p1_k;
    logic             r_p2_vld;
    logic [KW-1:0]    r_p2_k;
    logic             r_out_vld;
    logic             r_out_cell;

    logic             in_acc;
    logic             in_range;
    logic [XR-1:0]    row_x;
    logic [XC-1:0]    col_x;
    logic [RW-1:0]    in_row;
    logic [CW-1:0]    in_col;
    logic             slot_free;
    logic             step_end;
    logic [WIDTH-1:0] eff_row;
    logic [WIDTH-1:0] mod_row;
    logic [WIDTH-1:0] chain_in;
    logic [WIDTH-1:0] chain_out;
    logic [KW-1:0]    wb_k;

    logic             in_rdy;
    logic             rd_en;
    logic [RW-1:0]    rd_addr;
    logic             wr_en;
    logic [RW-1:0]    wr_addr;
    logic [WIDTH-1:0] wr_data;
    logic             res_ld;
    logic             res_val;
    logic             iss;

    assign row_x     = XR'(i_in.row);
    assign col_x     = XC'(i_in.col);
    assign in_row    = row_x[RW-1:0];
    assign in_col    = col_x[CW-1:0];
    assign in_range  = (32'(i_in.row) < 32'(HEIGHT)) && (32'(i_in.col) < 32'(WIDTH));
    assign in_acc    = i_in.valid && in_rdy;
    assign slot_free = !r_out_vld || o_out.ready;
    assign step_end  = r_p2_vld && (r_p2_k == K_LAST);
    assign eff_row   = r_rd_vld ? r_rd_data : '0;
    assign chain_in  = r_p1_zero ? '0 : eff_row;
    assign wb_k      = r_p2_k - KW'(1);

    always_comb begin
        mod_row        = eff_row;
        mod_row[r_col] = r_cell_in;
    end

    lgge_chain #(
        .WIDTH (WIDTH)
    ) u_chain (
        .i_clk      (i_clk),
        .i_shift    (r_p1_vld),
        .i_row_bits (chain_in),
        .o_next     (chain_out)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state) inside
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.operation)
                        OP_WRITE: n_state = in_range ? S_WR : S_DONE;
                        OP_STEP:  n_state = S_STEP;
                        OP_READ:  n_state = in_range ? S_RD : S_DONE;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_WR, S_RD, S_DONE: begin
                if (slot_free) begin
                    n_state = S_IDLE;
                end
            end
            S_STEP: begin
                if (step_end) begin
                    n_state = S_DONE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        in_rdy  = 1'b0;
        rd_en   = 1'b0;
        rd_addr = in_row;
        wr_en   = 1'b0;
        wr_addr = r_row;
        wr_data = mod_row;
        res_ld  = 1'b0;
        res_val = 1'b0;
        iss     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                in_rdy = 1'b1;
                rd_en  = in_acc && in_range &&
                         ((i_in.operation == OP_WRITE) || (i_in.operation == OP_READ));
            end
            S_WR: begin
                wr_en  = slot_free;
                res_ld = slot_free;
            end
            S_RD: begin
                res_ld  = slot_free;
                res_val = eff_row[r_col];
            end
            S_DONE: begin
                res_ld = slot_free;
            end
            S_STEP: begin
                iss     = r_iss;
                rd_en   = r_iss && (r_k != K_LAST);
                rd_addr = r_k[RW-1:0];
                wr_en   = r_p2_vld && (r_p2_k != '0);
                wr_addr = wb_k[RW-1:0];
                // border rows always die
                wr_data = ((r_p2_k == KW'(1)) || (r_p2_k == K_LAST)) ? '0 : chain_out;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_row     <= in_row;
            r_col     <= in_col;
            r_cell_in <= i_in.cell_in;
        end
        if (in_acc) begin
            r_k <= '0;
        end else if (iss && (r_k != K_LAST)) begin
            r_k <= r_k + KW'(1);
        end
        r_p1_zero <= (r_k == K_LAST);
        r_p1_k    <= r_k;
        r_p2_k    <= r_p1_k;
        if (res_ld) begin
            r_out_cell <= res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_iss     <= 1'b0;
            r_p1_vld  <= 1'b0;
            r_p2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= iss;
            r_p2_vld <= r_p1_vld;
            if (wr_en) begin
                r_row_vld[wr_addr] <= 1'b1;
            end
            if (in_acc && (i_in.operation == OP_STEP)) begin
                r_iss <= 1'b1;
            end else if (iss && (r_k == K_LAST)) begin
                r_iss <= 1'b0;
            end
            if (res_ld) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign i_in.ready     = in_rdy;
    assign o_out.valid    = r_out_vld;
    assign o_out.cell_out = r_out_cell;

endmodule

// ===== rtl/lgge_checker.sv =====
// port-level checker for the life grid generation engine and its bind
`timescale 1ns / 1ps

module lgge_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_cell_out
);

    logic [1:0] r_pend;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + 2'(in_acc) - 2'(out_acc);
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cell_out))
        else $error("result beat dropped or changed while stalled");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> r_pend != 2'd0)
        else $error("result beat without a pending operation");

    a_pend_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend != 2'd3)
        else $error("too many operations pending");

    a_rst_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> !i_out_valid)
        else $error("result beat right after reset");

endmodule

bind life_grid_generation_engine lgge_checker u_lgge_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_cell_out  (o_out.cell_out)
);

// ===== sim/tb_life_grid_generation_engine.sv =====
// testbench for the life grid generation engine: board ops checked against a board predictor
`timescale 1ns / 1ps

module tb_life_grid_generation_engine;
    import lgge_pkg::*;

    localparam int ROWS = 50;
    localparam int COLS = 80;
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = ROWS + 16;

    typedef struct {
        logic [OP_W-1:0]  op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             cell_out;
    } t_cell_result;

    logic i_clk;
    logic i_rst_n;

    lgge_in_if  in_if ();
    lgge_out_if out_if ();

    life_grid_generation_engine #(
        .WIDTH  (COLS),
        .HEIGHT (ROWS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    bit           board_q [ROWS][COLS];
    t_cell_result cell_results_due [$];
    int           errors;
    int           quiet_cycles;
    int           stall_left;
    bit           result_taken;
    bit           gaps_on;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // board predictor, rule b3/s23 with a dead border
    function automatic int live_neighbours(int r, int c);
        int n;
        n = 0;
        if (r == 0 || c == 0 || r >= ROWS - 1 || c >= COLS - 1) return 0;
        for (int dr = -1; dr <= 1; dr++) begin
            for (int dc = -1; dc <= 1; dc++) begin
                if (dr != 0 || dc != 0) n += board_q[r + dr][c + dc];
            end
        end
        return n;
    endfunction

    function automatic void advance_board();
        bit next_board [ROWS][COLS];
        int n;
        for (int r = 0; r < ROWS; r++) begin
            for (int c = 0; c < COLS; c++) begin
                n = live_neighbours(r, c);
                next_board[r][c] = (n == BIRTH_CNT) || (board_q[r][c] && n == SURVIVE_CNT);
            end
        end
        board_q = next_board;
    endfunction

    function automatic logic predict_cell_out(logic [OP_W-1:0] op, logic [ROW_W-1:0] row,
                                              logic [COL_W-1:0] col, logic cell_val);
        bit on_board;
        on_board = (row < ROWS) && (col < COLS);
        case (op)
            OP_WRITE: begin
                if (on_board) board_q[row][col] = cell_val;
            end
            OP_STEP: begin
                advance_board();
            end
            OP_READ: begin
                if (on_board) return board_q[row][col];
            end
            default: begin
            end
        endcase
        return 1'b0;
    endfunction

    // one operation beat, with a random gap ahead of it while gaps_on is set
    task automatic issue_op(logic [OP_W-1:0] op, int row, int col, logic cell_val);
        int gap;
        t_cell_result due;
        gap = gaps_on ? $urandom_range(0, 3) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.operation <= op;
        in_if.row       <= row[ROW_W-1:0];
        in_if.col       <= col[COL_W-1:0];
        in_if.cell_in   <= cell_val;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        due.op       = op;
        due.row      = row[ROW_W-1:0];
        due.col      = col[COL_W-1:0];
        due.cell_out = predict_cell_out(op, row[ROW_W-1:0], col[COL_W-1:0], cell_val);
        cell_results_due.push_back(due);
    endtask

    // result side: stall counts down only while a result is offered
    always @(negedge i_clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            stall_left = gaps_on ? $urandom_range(0, 3) : 0;
        end
        if (stall_left > 0) begin
            out_if.ready <= 1'b0;
            if (out_if.valid === 1'b1) stall_left--;
        end else begin
            out_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_cell_result due;
        quiet_cycles++;
        if (i_rst_n && in_if.valid === 1'b1 && in_if.ready === 1'b1) quiet_cycles = 0;
        if (i_rst_n && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
            quiet_cycles = 0;
            result_taken = 1'b1;
            if (cell_results_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual cell_out %b",
                         $time, out_if.cell_out);
            end else begin
                due = cell_results_due.pop_front();
                if (out_if.cell_out !== due.cell_out) begin
                    errors++;
                    $display("%0t: op %0d row %0d col %0d: expected cell_out %b, actual %b",
                             $time, due.op, due.row, due.col, due.cell_out, out_if.cell_out);
                end
            end
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic test_reset_board();
        issue_op(OP_READ, 0, 0, 1'b1);
        issue_op(OP_READ, 25, 40, 1'b0);
    endtask

    task automatic test_corner_cells();
        issue_op(OP_WRITE, 0, 0, 1'b1);
        issue_op(OP_WRITE, ROWS - 1, COLS - 1, 1'b1);
        issue_op(OP_READ, 0, 0, 1'b0);
        issue_op(OP_READ, ROWS - 1, COLS - 1, 1'b0);
        issue_op(OP_WRITE, ROWS - 1, COLS - 1, 1'b0);
        issue_op(OP_READ, ROWS - 1, COLS - 1, 1'b1);
    endtask

    task automatic test_off_board();
        issue_op(OP_WRITE, 63, 127, 1'b1);
        issue_op(OP_WRITE, ROWS, 5, 1'b1);
        issue_op(OP_WRITE, 5, COLS, 1'b1);
        issue_op(OP_READ, ROWS, 5, 1'b0);
        issue_op(OP_READ, 63, 127, 1'b1);
    endtask

    task automatic test_unknown_op();
        issue_op(OP_UNUSED, 63, 127, 1'b1);
        issue_op(OP_UNUSED, 0, 0, 1'b0);
        issue_op(OP_READ, 0, 0, 1'b0);
    endtask

    // horizontal blinker turns vertical, border cell dies
    task automatic test_blinker_step();
        issue_op(OP_WRITE, 2, 3, 1'b1);
        issue_op(OP_WRITE, 2, 4, 1'b1);
        issue_op(OP_WRITE, 2, 5, 1'b1);
        issue_op(OP_STEP, 63, 127, 1'b1);
        issue_op(OP_READ, 1, 4, 1'b0);
        issue_op(OP_READ, 3, 4, 1'b0);
        issue_op(OP_READ, 2, 3, 1'b0);
        issue_op(OP_READ, 2, 4, 1'b0);
        issue_op(OP_READ, 0, 0, 1'b0);
    endtask

    // bursts of writes, reads and steps in a window, with some noise
    task automatic test_random_traffic();
        int base_r;
        int base_c;
        int pick;
        for (int burst = 0; burst < 6; burst++) begin
            gaps_on = (burst % 3) != 2;
            case ($urandom_range(0, 2))
                0: base_r = 0;
                1: base_r = 20;
                default: base_r = ROWS - 8;
            endcase
            case ($urandom_range(0, 2))
                0: base_c = 0;
                1: base_c = 35;
                default: base_c = COLS - 10;
            endcase
            for (int k = 0; k < 20; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 45) begin
                    issue_op(OP_WRITE, base_r + $urandom_range(0, 7),
                             base_c + $urandom_range(0, 9), 1'($urandom_range(0, 1)));
                end else if (pick < 75) begin
                    issue_op(OP_READ, base_r + $urandom_range(0, 7),
                             base_c + $urandom_range(0, 9), 1'($urandom_range(0, 1)));
                end else if (pick < 85) begin
                    issue_op(OP_STEP, $urandom_range(0, 63), $urandom_range(0, 127),
                             1'($urandom_range(0, 1)));
                end else begin
                    issue_op(OP_W'($urandom_range(0, 3)), $urandom_range(0, 63),
                             $urandom_range(0, 127), 1'($urandom_range(0, 1)));
                end
            end
        end
        gaps_on = 1'b1;
    endtask

    initial begin
        i_rst_n         = 1'b0;
        in_if.valid     = 1'b0;
        in_if.operation = OP_WRITE;
        in_if.row       = '0;
        in_if.col       = '0;
        in_if.cell_in   = 1'b0;
        out_if.ready    = 1'b0;
        errors          = 0;
        quiet_cycles    = 0;
        stall_left      = 0;
        result_taken    = 1'b0;
        gaps_on         = 1'b1;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_board();
        test_corner_cells();
        test_off_board();
        test_unknown_op();
        test_blinker_step();
        test_random_traffic();

        @(negedge i_clk);
        in_if.valid <= 1'b0;
        while (cell_results_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0 && cell_results_due.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
